// ===== rtl/oriented_box_sphere_overlap_test_macros.svh =====
// Assertion macros shared by the overlap test RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ORIENTED_BOX_SPHERE_OVERLAP_TEST_MACROS_SVH
`define ORIENTED_BOX_SPHERE_OVERLAP_TEST_MACROS_SVH

// same-cycle implication, disabled in reset
`define OBSOT_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("obsot: same-cycle check failed");

// next-cycle implication, disabled in reset
`define OBSOT_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("obsot: next-cycle check failed");

// next-cycle implication, live through reset
`define OBSOT_ASSERT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("obsot: reset check failed");

`endif

// ===== rtl/obsot_pkg.sv =====
// Package for the oriented box / sphere overlap test.
// Types, defaults and the quarter-wave sine table; no dependencies.
`default_nettype none
package obsot_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int PHASE_BITS     = 16;
  localparam int FRAC_BITS      = 16;
  localparam int TRIG_BITS      = 18;

  typedef logic signed [TRIG_BITS-1:0] trig_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sincos_t;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  localparam logic [16:0] QSINE [0:16] = '{
    17'd0,     17'd6424,  17'd12785, 17'd19024, 17'd25080, 17'd30893,
    17'd36410, 17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798,
    17'd60547, 17'd62714, 17'd64277, 17'd65220, 17'd65536
  };

  function automatic logic [16:0] quarter_lookup(input logic [14:0] p);
    logic [3:0]  i;
    logic [9:0]  f;
    logic [16:0] a;
    logic [16:0] b;
    logic [12:0] diff;
    logic [22:0] prod;
    i    = p[13:10];
    f    = p[9:0];
    a    = QSINE[i];
    b    = QSINE[5'(i) + 5'd1];
    diff = 13'(b - a);
    prod = 23'(diff) * 23'(f) + 23'd512;
    if (p[14]) begin
      return 17'd65536;
    end
    return a + 17'(prod[22:10]);
  endfunction

  function automatic sincos_t sine_cosine(input logic [PHASE_BITS-1:0] ph);
    logic [14:0] r;
    trig_t       sr;
    trig_t       cr;
    sincos_t     o;
    r  = {1'b0, ph[13:0]};
    sr = trig_t'({1'b0, quarter_lookup(r)});
    cr = trig_t'({1'b0, quarter_lookup(15'd16384 - r)});
    case (ph[15:14])
      2'd0:    begin o.s = sr;  o.c = cr;  end
      2'd1:    begin o.s = cr;  o.c = -sr; end
      2'd2:    begin o.s = -sr; o.c = -cr; end
      default: begin o.s = -cr; o.c = sr;  end
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/obsot_if.sv =====
// Request and response channel interfaces of the overlap test.
// Depends on obsot_pkg for default widths.
`default_nettype none
interface obsot_req_if #(
  parameter int COORD_BITS = obsot_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = obsot_pkg::ANGLE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_x;
  logic signed [COORD_BITS-1:0] box_y;
  logic signed [COORD_BITS-1:0] box_z;
  logic        [COORD_BITS-2:0] box_width;
  logic        [COORD_BITS-2:0] box_height;
  logic        [COORD_BITS-2:0] box_depth;
  logic        [ANGLE_BITS-1:0] box_angle;
  logic signed [COORD_BITS-1:0] sphere_x;
  logic signed [COORD_BITS-1:0] sphere_y;
  logic signed [COORD_BITS-1:0] sphere_z;
  logic        [COORD_BITS-2:0] sphere_radius;

  modport source (output valid, box_x, box_y, box_z, box_width, box_height, box_depth,
                  box_angle, sphere_x, sphere_y, sphere_z, sphere_radius, input ready);
  modport sink   (input valid, box_x, box_y, box_z, box_width, box_height, box_depth,
                  box_angle, sphere_x, sphere_y, sphere_z, sphere_radius, output ready);
endinterface

interface obsot_rsp_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface
`default_nettype wire

// ===== rtl/obsot_front.sv =====
// Stage 1: center offsets and sine/cosine lookup.
// Depends on obsot_pkg.
`default_nettype none
module obsot_front #(
  parameter int COORD_BITS = obsot_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = obsot_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  obsot_pkg::pipe_ctl_t         ctl_in,
  input  logic signed [COORD_BITS-1:0] box_x,
  input  logic signed [COORD_BITS-1:0] box_y,
  input  logic signed [COORD_BITS-1:0] box_z,
  input  logic        [COORD_BITS-2:0] box_width,
  input  logic        [COORD_BITS-2:0] box_height,
  input  logic        [COORD_BITS-2:0] box_depth,
  input  logic        [ANGLE_BITS-1:0] box_angle,
  input  logic signed [COORD_BITS-1:0] sphere_x,
  input  logic signed [COORD_BITS-1:0] sphere_y,
  input  logic signed [COORD_BITS-1:0] sphere_z,
  input  logic        [COORD_BITS-2:0] sphere_radius,
  output logic                         valid,
  output logic signed [COORD_BITS:0]   dx,
  output logic signed [COORD_BITS:0]   dy,
  output logic signed [COORD_BITS:0]   dz,
  output obsot_pkg::sincos_t           sc,
  output logic        [COORD_BITS-2:0] full_w,
  output logic        [COORD_BITS-2:0] full_h,
  output logic        [COORD_BITS-2:0] full_d,
  output logic        [COORD_BITS-2:0] radius
);
  import obsot_pkg::*;

  logic [PHASE_BITS-1:0] phase;

  generate
    if (ANGLE_BITS >= PHASE_BITS) begin : g_down
      assign phase = box_angle[ANGLE_BITS-1 -: PHASE_BITS];
    end else begin : g_up
      assign phase = {box_angle, {(PHASE_BITS-ANGLE_BITS){1'b0}}};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl_in.en) begin
      valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      dx     <= (COORD_BITS+1)'(sphere_x) - (COORD_BITS+1)'(box_x);
      dy     <= (COORD_BITS+1)'(sphere_y) - (COORD_BITS+1)'(box_y);
      dz     <= (COORD_BITS+1)'(sphere_z) - (COORD_BITS+1)'(box_z);
      sc     <= sine_cosine(phase);
      full_w <= box_width;
      full_h <= box_height;
      full_d <= box_depth;
      radius <= sphere_radius;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/obsot_rotate.sv =====
// Stages 2-3: rotation of the offset into box-local x and y with rounding.
// Depends on obsot_pkg.
`default_nettype none
module obsot_rotate #(
  parameter int COORD_BITS = obsot_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  obsot_pkg::pipe_ctl_t                  ctl_in,
  input  logic signed [COORD_BITS:0]            dx,
  input  logic signed [COORD_BITS:0]            dy,
  input  logic signed [COORD_BITS:0]            dz,
  input  obsot_pkg::sincos_t                    sc,
  input  logic        [COORD_BITS-2:0]          full_w,
  input  logic        [COORD_BITS-2:0]          full_h,
  input  logic        [COORD_BITS-2:0]          full_d,
  input  logic        [COORD_BITS-2:0]          radius,
  output logic                                  valid,
  output logic signed [COORD_BITS+3:0]          lx,
  output logic signed [COORD_BITS+3:0]          ly,
  output logic signed [COORD_BITS:0]            lz,
  output logic        [COORD_BITS-2:0]          out_w,
  output logic        [COORD_BITS-2:0]          out_h,
  output logic        [COORD_BITS-2:0]          out_d,
  output logic        [COORD_BITS-2:0]          out_r
);
  import obsot_pkg::*;

  localparam int PROD_BITS = TRIG_BITS + COORD_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam logic signed [SUM_BITS-1:0] HALF = SUM_BITS'(1 << (FRAC_BITS - 1));

  logic                         v2;
  logic signed [PROD_BITS-1:0]  pcx;
  logic signed [PROD_BITS-1:0]  psy;
  logic signed [PROD_BITS-1:0]  pcy;
  logic signed [PROD_BITS-1:0]  psx;
  logic signed [COORD_BITS:0]   dz2;
  logic        [COORD_BITS-2:0] w2;
  logic        [COORD_BITS-2:0] h2;
  logic        [COORD_BITS-2:0] d2;
  logic        [COORD_BITS-2:0] r2;
  logic signed [SUM_BITS-1:0]   sum_x;
  logic signed [SUM_BITS-1:0]   sum_y;

  always_comb begin
    sum_x = SUM_BITS'(pcx) + SUM_BITS'(psy) + HALF;
    sum_y = SUM_BITS'(pcy) - SUM_BITS'(psx) + HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2    <= 1'b0;
      valid <= 1'b0;
    end else if (ctl_in.en) begin
      v2    <= ctl_in.valid;
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      pcx   <= PROD_BITS'(sc.c) * PROD_BITS'(dx);
      psy   <= PROD_BITS'(sc.s) * PROD_BITS'(dy);
      pcy   <= PROD_BITS'(sc.c) * PROD_BITS'(dy);
      psx   <= PROD_BITS'(sc.s) * PROD_BITS'(dx);
      dz2   <= dz;
      w2    <= full_w;
      h2    <= full_h;
      d2    <= full_d;
      r2    <= radius;
      lx    <= sum_x[SUM_BITS-1:FRAC_BITS];
      ly    <= sum_y[SUM_BITS-1:FRAC_BITS];
      lz    <= dz2;
      out_w <= w2;
      out_h <= h2;
      out_d <= d2;
      out_r <= r2;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/obsot_dist.sv =====
// Stages 4-6: clamp excess per axis, squares, sum and compare with radius.
// Depends on obsot_pkg and the assertion macro header.
`default_nettype none
`include "oriented_box_sphere_overlap_test_macros.svh"
module obsot_dist #(
  parameter int COORD_BITS = obsot_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  obsot_pkg::pipe_ctl_t         ctl_in,
  input  logic signed [COORD_BITS+3:0] lx,
  input  logic signed [COORD_BITS+3:0] ly,
  input  logic signed [COORD_BITS:0]   lz,
  input  logic        [COORD_BITS-2:0] full_w,
  input  logic        [COORD_BITS-2:0] full_h,
  input  logic        [COORD_BITS-2:0] full_d,
  input  logic        [COORD_BITS-2:0] radius,
  output logic                         valid,
  output logic                         hit
);
  import obsot_pkg::*;

  localparam int LX_BITS  = COORD_BITS + 4;
  localparam int EX_BITS  = COORD_BITS + 2;
  localparam int SQ_BITS  = 2 * EX_BITS;
  localparam int SUM_BITS = SQ_BITS + 2;
  localparam int RQ_BITS  = 2 * COORD_BITS;

  function automatic logic [EX_BITS-1:0] excess(input logic signed [LX_BITS-1:0] p,
                                               input logic [COORD_BITS-2:0] full);
    logic [LX_BITS-1:0] mag;
    logic [LX_BITS:0]   m;
    logic [LX_BITS:0]   f;
    mag = p[LX_BITS-1] ? LX_BITS'(-p) : LX_BITS'(p);
    m   = {mag, 1'b0};
    f   = (LX_BITS+1)'(full);
    return (m > f) ? EX_BITS'(m - f) : '0;
  endfunction

  logic                    v4;
  logic                    v5;
  logic [EX_BITS-1:0]      ex;
  logic [EX_BITS-1:0]      ey;
  logic [EX_BITS-1:0]      ez;
  logic [COORD_BITS-1:0]   rr;
  logic [SQ_BITS-1:0]      sq_x;
  logic [SQ_BITS-1:0]      sq_y;
  logic [SQ_BITS-1:0]      sq_z;
  logic [RQ_BITS-1:0]      sq_r;
  logic [SUM_BITS-1:0]     total;

  assign total = SUM_BITS'(sq_x) + SUM_BITS'(sq_y) + SUM_BITS'(sq_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4    <= 1'b0;
      v5    <= 1'b0;
      valid <= 1'b0;
    end else if (ctl_in.en) begin
      v4    <= ctl_in.valid;
      v5    <= v4;
      valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      ex   <= excess(lx, full_w);
      ey   <= excess(ly, full_h);
      ez   <= excess(LX_BITS'(lz), full_d);
      rr   <= {radius, 1'b0};
      sq_x <= SQ_BITS'(ex) * SQ_BITS'(ex);
      sq_y <= SQ_BITS'(ey) * SQ_BITS'(ey);
      sq_z <= SQ_BITS'(ez) * SQ_BITS'(ez);
      sq_r <= RQ_BITS'(rr) * RQ_BITS'(rr);
      hit  <= total <= SUM_BITS'(sq_r);
    end
  end

  // a center on or inside the box always hits
  `OBSOT_ASSERT_NEXT(a_inside_hits, clk, rst,
    ctl_in.en && v5 && sq_x == '0 && sq_y == '0 && sq_z == '0, hit)

endmodule
`default_nettype wire

// ===== rtl/oriented_box_sphere_overlap_test.sv =====
// Oriented box versus sphere overlap test, top level.
// Depends on obsot_pkg, obsot_if, obsot_front, obsot_rotate, obsot_dist and the macro header.
//
// Usage:
//   req carries one query per beat: box center, full extents, angle about z
//   and sphere center and radius. rsp returns one beat per query with hit,
//   in query order.
//   Stages, in order from the accepting edge to rsp.valid: offsets/trig,
//   products, rotate/round, clamp, squares, compare.
//   Throughput: one query per cycle while rsp is not stalled; every stage is
//   a register with a valid bit.
//   Stall: the whole pipeline advances together. While rsp.valid is high
//   and rsp.ready low, req.ready is low and every stage holds its beat.
//   Reset: synchronous rst empties the pipeline; req.ready is high from the
//   first cycle after reset.
`default_nettype none
`include "oriented_box_sphere_overlap_test_macros.svh"
module oriented_box_sphere_overlap_test #(
  parameter int COORD_BITS = obsot_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = obsot_pkg::ANGLE_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  obsot_req_if.sink   req,
  obsot_rsp_if.source rsp
);
  import obsot_pkg::*;

  logic                         en;
  pipe_ctl_t                    ctl_req;
  pipe_ctl_t                    ctl_front;
  pipe_ctl_t                    ctl_rot;
  logic                         v_front;
  logic                         v_rot;
  logic signed [COORD_BITS:0]   dx;
  logic signed [COORD_BITS:0]   dy;
  logic signed [COORD_BITS:0]   dz;
  sincos_t                      sc;
  logic        [COORD_BITS-2:0] f_w;
  logic        [COORD_BITS-2:0] f_h;
  logic        [COORD_BITS-2:0] f_d;
  logic        [COORD_BITS-2:0] f_r;
  logic signed [COORD_BITS+3:0] lx;
  logic signed [COORD_BITS+3:0] ly;
  logic signed [COORD_BITS:0]   lz;
  logic        [COORD_BITS-2:0] r_w;
  logic        [COORD_BITS-2:0] r_h;
  logic        [COORD_BITS-2:0] r_d;
  logic        [COORD_BITS-2:0] r_r;

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;
  assign ctl_req   = '{en: en, valid: req.valid};
  assign ctl_front = '{en: en, valid: v_front};
  assign ctl_rot   = '{en: en, valid: v_rot};

  obsot_front #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk, .rst, .ctl_in(ctl_req),
    .box_x(req.box_x), .box_y(req.box_y), .box_z(req.box_z),
    .box_width(req.box_width), .box_height(req.box_height), .box_depth(req.box_depth),
    .box_angle(req.box_angle),
    .sphere_x(req.sphere_x), .sphere_y(req.sphere_y), .sphere_z(req.sphere_z),
    .sphere_radius(req.sphere_radius),
    .valid(v_front), .dx, .dy, .dz, .sc,
    .full_w(f_w), .full_h(f_h), .full_d(f_d), .radius(f_r)
  );

  obsot_rotate #(.COORD_BITS(COORD_BITS)) u_rotate (
    .clk, .rst, .ctl_in(ctl_front),
    .dx, .dy, .dz, .sc,
    .full_w(f_w), .full_h(f_h), .full_d(f_d), .radius(f_r),
    .valid(v_rot), .lx, .ly, .lz,
    .out_w(r_w), .out_h(r_h), .out_d(r_d), .out_r(r_r)
  );

  obsot_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk, .rst, .ctl_in(ctl_rot),
    .lx, .ly, .lz,
    .full_w(r_w), .full_h(r_h), .full_d(r_d), .radius(r_r),
    .valid(rsp.valid), .hit(rsp.hit)
  );

  `OBSOT_ASSERT_ALWAYS(a_reset_empties, clk, rst, !rsp.valid)
  `OBSOT_ASSERT_NEXT(a_stall_freezes, clk, rst, !en, $stable(v_front) && $stable(v_rot))

endmodule
`default_nettype wire
